FILE: design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared types and constants of the two-level page table manager
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int DIR_ENTRIES = 1024;
  localparam int DIR_W       = 10;
  localparam int IDX_W       = 10;
  localparam int OFF_W       = 12;
  localparam int FRAME_W     = 20;
  localparam int ADDR_W      = 32;
  localparam int ENTRY_W     = FRAME_W + 1;

  localparam logic [FRAME_W-1:0] LAST_FRAME      = 20'hfffff;
  localparam logic [FRAME_W-1:0] FIRST_FRAME_RST = 20'd256;
  localparam logic [ADDR_W-1:0]  ADDR_UNMAPPED   = 32'hffffffff;

  typedef enum logic [1:0] {
    KIND_MAP       = 2'd0,
    KIND_UNMAP     = 2'd1,
    KIND_TRANSLATE = 2'd2,
    KIND_FAULT     = 2'd3
  } kind_t;

endpackage

FILE: design/tlpt_if.sv
// ----------------------------------------------------------------------------
// tlpt_req_if / tlpt_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface tlpt_req_if import tlpt_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [ADDR_W-1:0] virt_addr;
  logic [ADDR_W-1:0] phys_addr;

  modport source (output valid, output kind, output virt_addr, output phys_addr,
                  input ready);
  modport sink   (input valid, input kind, input virt_addr, input phys_addr,
                  output ready);
endinterface

interface tlpt_rsp_if import tlpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_addr;
  logic              mapped;
  logic              dirty;
  logic              accessed;
  logic              error;

  modport source (output valid, output result_addr, output mapped, output dirty,
                  output accessed, output error, input ready);
  modport sink   (input valid, input result_addr, input mapped, input dirty,
                  input accessed, input error, output ready);
endinterface

FILE: design/two_level_page_table_manager_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager_top
// two-level page table store with a bump frame allocator
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to zero, one page table entry a
// cycle; no request is taken until the sweep is done, while first_frame
// writes are taken only until the first request that allocates frames. A
// request then passes through the transfer cycle, a directory read, and a
// page table read with its write back; a request that fails on table slots
// or frames finishes after the directory read. The directory memory and the
// page table memory each have a registered read, and the block works on one
// request at a time. The result waits in an output register, so the next
// request may be taken before the previous result is collected.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_top
  import tlpt_pkg::*;
#(
  parameter int MAX_TABLES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata,
  tlpt_req_if.sink           req,
  tlpt_rsp_if.source         rsp
);

  localparam int SLOT_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int TU_W       = $clog2(MAX_TABLES + 1);
  localparam int PAGE_DEPTH = MAX_TABLES * DIR_ENTRIES;
  localparam int PAGE_AW    = SLOT_W + IDX_W;
  localparam int DIR_DW     = SLOT_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DIR   = 4'b0100,
    ST_PAGE  = 4'b1000
  } state_t;

  state_t             state;
  logic [PAGE_AW-1:0] clr_addr;
  logic [FRAME_W-1:0] next_frame;
  logic               dir_allocated;
  logic [TU_W-1:0]    tables_used;

  kind_t              req_kind;
  logic [DIR_W-1:0]   req_dir;
  logic [IDX_W-1:0]   req_idx;
  logic [OFF_W-1:0]   req_off;
  logic [FRAME_W-1:0] req_pfn;
  logic [PAGE_AW-1:0] page_addr;
  logic [FRAME_W-1:0] data_frame;

  logic               out_valid;
  logic [ADDR_W-1:0]  out_addr;
  logic               out_mapped;
  logic               out_error;

  logic               dir_we;
  logic [DIR_W-1:0]   dir_waddr;
  logic [DIR_DW-1:0]  dir_wdata;
  logic [DIR_W-1:0]   dir_raddr;
  logic [DIR_DW-1:0]  dir_rdata;

  logic               page_we;
  logic [PAGE_AW-1:0] page_waddr;
  logic [ENTRY_W-1:0] page_wdata;
  logic [PAGE_AW-1:0] page_raddr;
  logic [ENTRY_W-1:0] page_rdata;

  logic               in_fire;
  logic               out_free;
  logic               out_load;
  logic               clearing;
  logic               need_table;
  logic [1:0]         need_frames;
  logic [FRAME_W:0]   frame_sum;
  logic               req_err;
  logic [SLOT_W-1:0]  slot_sel;
  logic [ENTRY_W-1:0] entry_next;
  logic [ADDR_W-1:0]  result_next;
  logic               mapped_next;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign out_load = out_free && (((state == ST_DIR) && req_err) || (state == ST_PAGE));
  assign clearing = (state == ST_CLEAR);

  assign req.ready = (state == ST_IDLE);

  // allocation check on the directory entry
  always_comb begin
    need_table  = !dir_rdata[DIR_DW-1];
    need_frames = 2'((req_kind == KIND_FAULT)) + 2'(!dir_allocated) + 2'(need_table);
    frame_sum   = (FRAME_W + 1)'(next_frame) + (FRAME_W + 1)'(need_frames);
    req_err     = (frame_sum > (FRAME_W + 1)'(LAST_FRAME)) ||
                  (need_table && (tables_used >= TU_W'(MAX_TABLES)));
    slot_sel    = need_table ? tables_used[SLOT_W-1:0] : dir_rdata[SLOT_W-1:0];
  end

  // page entry update and result
  always_comb begin
    entry_next  = page_rdata;
    result_next = '0;
    mapped_next = 1'b0;
    case (req_kind)
      KIND_MAP: begin
        entry_next = {req_pfn, 1'b1};
      end
      KIND_UNMAP: begin
        entry_next = {page_rdata[ENTRY_W-1:1], 1'b0};
      end
      KIND_TRANSLATE: begin
        mapped_next = page_rdata[0];
        result_next = page_rdata[0] ? {page_rdata[ENTRY_W-1:1], req_off} : ADDR_UNMAPPED;
      end
      default: begin
        entry_next  = {data_frame, 1'b1};
        result_next = {data_frame, {OFF_W{1'b0}}};
      end
    endcase
  end

  // memory ports
  always_comb begin
    dir_raddr  = (state == ST_IDLE) ? req.virt_addr[ADDR_W-1 -: DIR_W] : req_dir;
    dir_we     = clearing ? (clr_addr < PAGE_AW'(DIR_ENTRIES))
                          : ((state == ST_DIR) && !req_err && need_table);
    dir_waddr  = clearing ? clr_addr[DIR_W-1:0] : req_dir;
    dir_wdata  = clearing ? '0 : {1'b1, tables_used[SLOT_W-1:0]};

    page_raddr = (state == ST_DIR) ? {slot_sel, req_idx} : page_addr;
    page_we    = clearing || ((state == ST_PAGE) && out_free && (req_kind != KIND_TRANSLATE));
    page_waddr = clearing ? clr_addr : page_addr;
    page_wdata = clearing ? '0 : entry_next;
  end

  tlpt_ram #(
    .WIDTH(DIR_DW),
    .DEPTH(DIR_ENTRIES),
    .AW   (DIR_W)
  ) u_dir_ram (
    .clk  (clk),
    .we   (dir_we),
    .waddr(dir_waddr),
    .wdata(dir_wdata),
    .raddr(dir_raddr),
    .rdata(dir_rdata)
  );

  tlpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PAGE_DEPTH),
    .AW   (PAGE_AW)
  ) u_page_ram (
    .clk  (clk),
    .we   (page_we),
    .waddr(page_waddr),
    .wdata(page_wdata),
    .raddr(page_raddr),
    .rdata(page_rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind <= req.kind;
      req_dir  <= req.virt_addr[ADDR_W-1 -: DIR_W];
      req_idx  <= req.virt_addr[OFF_W +: IDX_W];
      req_off  <= req.virt_addr[OFF_W-1:0];
      req_pfn  <= req.phys_addr[ADDR_W-1:OFF_W];
    end
    if (state == ST_DIR) begin
      page_addr  <= {slot_sel, req_idx};
      data_frame <= next_frame;
    end
  end

  // sequencer and allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      next_frame    <= FIRST_FRAME_RST;
      dir_allocated <= 1'b0;
      tables_used   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && !dir_allocated) begin
        next_frame <= cfg_wdata;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + PAGE_AW'(1);
          if (clr_addr == PAGE_AW'(PAGE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_DIR;
          end
        end
        ST_DIR: begin
          if (req_err) begin
            if (out_free) begin
              out_valid  <= 1'b1;
              out_addr   <= '0;
              out_mapped <= 1'b0;
              out_error  <= 1'b1;
              state      <= ST_IDLE;
            end
          end else begin
            next_frame    <= frame_sum[FRAME_W-1:0];
            dir_allocated <= 1'b1;
            if (need_table) begin
              tables_used <= tables_used + TU_W'(1);
            end
            state <= ST_PAGE;
          end
        end
        ST_PAGE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_addr   <= result_next;
            out_mapped <= mapped_next;
            out_error  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_addr = out_addr;
  assign rsp.mapped      = out_mapped;
  assign rsp.dirty       = 1'b0;
  assign rsp.accessed    = 1'b0;
  assign rsp.error       = out_error;

`ifndef SYNTHESIS
  a_tables_bound: assert property (@(posedge clk) disable iff (rst)
    tables_used <= TU_W'(MAX_TABLES))
    else $error("table slot count beyond its limit");

  a_accept_to_dir: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_DIR))
    else $error("accepted request did not start a directory read");

  a_frames_grow: assert property (@(posedge clk) disable iff (rst)
    (dir_allocated && $past(dir_allocated)) |-> (next_frame >= $past(next_frame)))
    else $error("frame allocator moved backward");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.error) |-> ((rsp.result_addr == '0) && !rsp.mapped))
    else $error("failed request carries a result");
`endif

endmodule

FILE: design/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/two_level_page_table_manager_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager_top_tb
// Self-checking bench for the page table manager. Requests go in through the
// request channel and are mirrored by a shadow copy of the directory, the
// page tables and the frame allocator, which works out the result due for
// each one. Every result that comes back is compared field by field with
// the oldest result due. First come directed requests: allocator exhaustion
// before the directory exists, address extremes, and each request kind on
// empty and filled entries. Then random map, fault, translate and unmap
// sequences on a small set of pages, mixed with stray requests, in phases
// with different request gaps and result stalls.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_top_tb;
  import tlpt_pkg::*;

  localparam int MAX_TABLES    = 16;
  localparam int PT_ENTRIES    = 1024;
  localparam int FRAME_ROOM    = 120;
  localparam int DIR_POOL      = 20;
  localparam int IDX_POOL      = 8;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic              mapped;
    logic              dirty;
    logic              accessed;
    logic              error;
  } page_rsp_t;

  class page_table_shadow;
    logic [FRAME_W-1:0] first_frame;
    bit                 dir_present [DIR_ENTRIES];
    int unsigned        dir_slot [DIR_ENTRIES];
    bit [ENTRY_W-1:0]   page_entry [MAX_TABLES*PT_ENTRIES];
    int unsigned        next_frame;
    bit                 dir_allocated;
    int unsigned        tables_used;
    page_rsp_t          due_results [$];
    int                 fails;

    function new();
      first_frame   = FIRST_FRAME_RST;
      next_frame    = 32'(FIRST_FRAME_RST);
      dir_allocated = 1'b0;
      tables_used   = 0;
      fails         = 0;
    endfunction

    function void note_first_frame(logic [FRAME_W-1:0] value);
      first_frame = value;
      if (!dir_allocated) next_frame = 32'(value);
    endfunction

    function void note_request(kind_t kind, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] pa);
      int unsigned        dir;
      int unsigned        pos;
      int unsigned        need;
      bit                 need_table;
      logic [FRAME_W-1:0] data_frame;
      page_rsp_t          rsp;
      dir        = 32'(va[31:22]);
      need_table = !dir_present[dir];
      need       = 0;
      rsp        = '0;
      data_frame = '0;
      if (kind == KIND_FAULT) need++;
      if (!dir_allocated) need++;
      if (need_table) need++;
      if ((need_table && tables_used >= MAX_TABLES) || next_frame + need > LAST_FRAME) begin
        rsp.error = 1'b1;
        due_results.push_back(rsp);
        return;
      end
      if (kind == KIND_FAULT) begin
        data_frame = next_frame[FRAME_W-1:0];
        next_frame++;
      end
      if (!dir_allocated) begin
        dir_allocated = 1'b1;
        next_frame++;
      end
      if (need_table) begin
        next_frame++;
        dir_present[dir] = 1'b1;
        dir_slot[dir]    = tables_used;
        tables_used++;
      end
      pos = (dir_slot[dir] % MAX_TABLES) * PT_ENTRIES + 32'(va[21:12]);
      case (kind)
        KIND_MAP: page_entry[pos] = {pa[31:12], 1'b1};
        KIND_UNMAP: page_entry[pos][0] = 1'b0;
        KIND_TRANSLATE: begin
          if (page_entry[pos][0]) begin
            rsp.mapped      = 1'b1;
            rsp.result_addr = {page_entry[pos][ENTRY_W-1:1], va[OFF_W-1:0]};
          end else begin
            rsp.result_addr = ADDR_UNMAPPED;
          end
        end
        default: begin
          page_entry[pos] = {data_frame, 1'b1};
          rsp.result_addr = {data_frame, {OFF_W{1'b0}}};
        end
      endcase
      due_results.push_back(rsp);
    endfunction

    function void check_result(page_rsp_t got);
      page_rsp_t want;
      if (due_results.size() == 0) begin
        $error("result_addr: expected nothing, got %h", got.result_addr);
        fails++;
        return;
      end
      want = due_results.pop_front();
      if (got.result_addr !== want.result_addr) begin
        $error("result_addr: expected %h, got %h", want.result_addr, got.result_addr);
        fails++;
      end
      if (got.mapped !== want.mapped) begin
        $error("mapped: expected %b, got %b", want.mapped, got.mapped);
        fails++;
      end
      if (got.dirty !== want.dirty) begin
        $error("dirty: expected %b, got %b", want.dirty, got.dirty);
        fails++;
      end
      if (got.accessed !== want.accessed) begin
        $error("accessed: expected %b, got %b", want.accessed, got.accessed);
        fails++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %b, got %b", want.error, got.error);
        fails++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  two_level_page_table_manager_top #(
    .MAX_TABLES(MAX_TABLES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  page_table_shadow shadow = new();

  int               req_idle_pct;
  int               rsp_stall_pct;
  logic [DIR_W-1:0] dir_pool [DIR_POOL];
  logic [IDX_W-1:0] idx_pool [IDX_POOL];

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("two_level_page_table_manager_top_tb: errors");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        shadow.check_result({rsp_ch.result_addr, rsp_ch.mapped, rsp_ch.dirty,
                             rsp_ch.accessed, rsp_ch.error});
    end
  end

  task automatic write_first_frame(logic [FRAME_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    shadow.note_first_frame(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic issue(kind_t kind, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] pa);
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.virt_addr <= va;
    req_ch.phys_addr <= pa;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    shadow.note_request(kind, va, pa);
    while ($urandom_range(99) < req_idle_pct) begin
      @(negedge clk);
      req_ch.valid     <= 1'b0;
      req_ch.virt_addr <= $urandom();
    end
  endtask

  // drop valid, wait for every result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(99) < 15) return $urandom();
    return {dir_pool[$urandom_range(DIR_POOL-1)], idx_pool[$urandom_range(IDX_POOL-1)],
            12'($urandom())};
  endfunction

  task automatic run_random(int count);
    int                sent = 0;
    logic [ADDR_W-1:0] va;
    while (sent < count) begin
      va = pick_addr();
      if ($urandom_range(99) < 65) begin
        issue($urandom_range(1) ? KIND_MAP : KIND_FAULT, va, $urandom());
        issue(KIND_TRANSLATE, {va[31:12], 12'($urandom())}, $urandom());
        sent += 2;
        if ($urandom_range(1)) begin
          issue(KIND_UNMAP, va, $urandom());
          issue(KIND_TRANSLATE, {va[31:12], 12'($urandom())}, $urandom());
          sent += 2;
        end
      end else begin
        issue(kind_t'($urandom_range(3)), va, $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_MAP;
    req_ch.virt_addr = '0;
    req_ch.phys_addr = '0;
    dir_pool[0] = 10'h000;
    dir_pool[1] = 10'h3ff;
    dir_pool[2] = 10'h048;
    dir_pool[3] = 10'h200;
    dir_pool[4] = 10'h100;
    for (int i = 5; i < DIR_POOL; i++) dir_pool[i] = DIR_W'($urandom_range(DIR_ENTRIES-1));
    idx_pool[0] = 10'h000;
    idx_pool[1] = 10'h3ff;
    idx_pool[2] = 10'h345;
    for (int i = 3; i < IDX_POOL; i++) idx_pool[i] = IDX_W'($urandom_range(PT_ENTRIES-1));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // allocator exhausted before the directory exists
    write_first_frame('0);
    write_first_frame(LAST_FRAME);
    issue(KIND_TRANSLATE, 32'h0000_0000, 32'h0000_0000);
    issue(KIND_FAULT, 32'hffff_ffff, 32'hffff_ffff);
    settle();
    write_first_frame(LAST_FRAME - FRAME_W'(1));
    issue(KIND_MAP, 32'h0040_0000, 32'h1234_5000);
    settle();

    write_first_frame(LAST_FRAME - FRAME_W'(FRAME_ROOM));
    issue(KIND_TRANSLATE, 32'h0000_0000, 32'h0000_0000);
    issue(KIND_MAP, 32'h0000_0000, 32'hffff_ffff);
    issue(KIND_TRANSLATE, 32'h0000_0fff, 32'h0000_0000);
    issue(KIND_MAP, 32'hffff_ffff, 32'h0000_0000);
    issue(KIND_TRANSLATE, 32'hffff_ffff, 32'hffff_ffff);
    issue(KIND_UNMAP, 32'h0000_0000, 32'h0000_0000);
    issue(KIND_TRANSLATE, 32'h0000_0abc, 32'h0000_0000);
    issue(KIND_UNMAP, 32'hffff_ffff, 32'h0000_0000);
    issue(KIND_MAP, 32'hffff_f000, 32'h8765_4321);
    issue(KIND_TRANSLATE, 32'hffff_f123, 32'h0000_0000);
    issue(KIND_FAULT, 32'h1234_5678, 32'h0000_0000);
    issue(KIND_TRANSLATE, 32'h1234_5678, 32'h0000_0000);
    issue(KIND_FAULT, 32'h0000_0000, 32'h5555_5555);
    issue(KIND_TRANSLATE, 32'h0000_0001, 32'h0000_0000);
    issue(KIND_UNMAP, 32'h8000_0000, 32'haaaa_aaaa);
    issue(KIND_TRANSLATE, 32'h8000_0000, 32'h0000_0000);
    issue(KIND_TRANSLATE, 32'h4000_0000, 32'h0000_0000);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          req_idle_pct  = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          req_idle_pct  = 87;
          rsp_stall_pct = 0;
        end
        2: begin
          req_idle_pct  = 0;
          rsp_stall_pct = 87;
        end
        default: begin
          req_idle_pct  = 29;
          rsp_stall_pct = 29;
        end
      endcase
      run_random(180);
      settle();
      case (phase)
        0: write_first_frame(FRAME_W'($urandom_range(LAST_FRAME)));
        1: write_first_frame('0);
        default: write_first_frame(LAST_FRAME);
      endcase
    end

    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    settle();
    if (shadow.fails == 0)
      $display("two_level_page_table_manager_top_tb: clean");
    else
      $display("two_level_page_table_manager_top_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
design/tlpt_pkg.sv
design/tlpt_if.sv
design/tlpt_ram.sv
design/two_level_page_table_manager_top.sv
test/two_level_page_table_manager_top_tb.sv
